// ===== rtl/core/dipt_pkg.sv =====
// Shared types and constants for the display idle power timer.
`default_nettype none

package dipt_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 31;
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DELAY_W-1:0] MAX_DELAY = {DELAY_W{1'b1}};

  localparam logic [LEVEL_W-1:0] LVL_ON      = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_STANDBY = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_SUSPEND = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_OFF     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PM_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STANDBY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSPEND      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAVER        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAVER_REPEAT = 3'd5;

  typedef struct packed {
    logic               power_mgmt_enable;
    logic [DELAY_W-1:0] standby_after_ms;
    logic [DELAY_W-1:0] suspend_after_ms;
    logic [DELAY_W-1:0] off_after_ms;
    logic [DELAY_W-1:0] saver_after_ms;
    logic [DELAY_W-1:0] saver_repeat_ms;
  } dipt_cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_next;
    logic               level_changed;
    logic               saver_activate;
    logic [DELAY_W-1:0] next_check_ms;
  } dipt_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/display_idle_power_timer_core.sv =====
// Top level of the display idle power timer: config registers, input and result stages.
//
//  channel | direction | transfer when        | payload
//  in_     | input     | in_valid & !in_stall | now_ms, last_activity_ms, level_now
//  out_    | output    | out_valid & !out_stall | level_next, level_changed,
//          |           |                      | saver_activate, next_check_ms
//  cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
//  One check per cycle when the output is not stalled; an input is held in the input register,
//  evaluated by the evaluation logic, and its result is held in the result register,
//  which presents it on the out_ channel.
//  Synchronous active-low reset clears the config registers and both stage valids.
//  A stalled result holds the result register; the input stage keeps taking
//  items until it is also full, then in_stall rises.
`default_nettype none

module display_idle_power_timer_core (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_we,
  input  logic [dipt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dipt_pkg::DELAY_W-1:0]      cfg_wdata,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dipt_pkg::TIME_W-1:0]       in_now_ms,
  input  logic [dipt_pkg::TIME_W-1:0]       in_last_activity_ms,
  input  logic [dipt_pkg::LEVEL_W-1:0]      in_level_now,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dipt_pkg::LEVEL_W-1:0]      out_level_next,
  output logic                              out_level_changed,
  output logic                              out_saver_activate,
  output logic [dipt_pkg::DELAY_W-1:0]      out_next_check_ms
);
  import dipt_pkg::*;

  dipt_cfg_t cfg_r;

  logic               s1_valid_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic [TIME_W-1:0]  s1_last_r;
  logic [LEVEL_W-1:0] s1_level_r;

  logic      out_valid_r;
  dipt_res_t out_res_r;
  dipt_res_t res;

  logic out_ready;
  logic s1_take;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_take   = !s1_valid_r || out_ready;
  assign in_stall  = !s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PM_ENABLE:    cfg_r.power_mgmt_enable <= cfg_wdata[0];
        REG_STANDBY:      cfg_r.standby_after_ms  <= cfg_wdata;
        REG_SUSPEND:      cfg_r.suspend_after_ms  <= cfg_wdata;
        REG_OFF:          cfg_r.off_after_ms      <= cfg_wdata;
        REG_SAVER:        cfg_r.saver_after_ms    <= cfg_wdata;
        REG_SAVER_REPEAT: cfg_r.saver_repeat_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_now_r   <= in_now_ms;
      s1_last_r  <= in_last_activity_ms;
      s1_level_r <= in_level_now;
    end
  end

  dipt_eval u_eval (
    .cfg              (cfg_r),
    .now_ms           (s1_now_r),
    .last_activity_ms (s1_last_r),
    .level_now        (s1_level_r),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_level_next     = out_res_r.level_next;
  assign out_level_changed  = out_res_r.level_changed;
  assign out_saver_activate = out_res_r.saver_activate;
  assign out_next_check_ms  = out_res_r.next_check_ms;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid set right after reset");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_saver_only_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_saver_activate) |-> (out_level_next == LVL_ON))
    else $error("saver activated at a lowered power level");

  a_change_raises: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_level_changed) |-> (out_level_next != LVL_ON))
    else $error("level change reported without a raise");

  a_move_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_ready) |=> out_valid_r)
    else $error("input stage item lost on its way to the result register");

endmodule

`default_nettype wire

// ===== rtl/core/dipt_eval.sv =====
// Idle time evaluation: power level escalation, saver decision and next check delay.
`default_nettype none

module dipt_eval (
  input  dipt_pkg::dipt_cfg_t             cfg,
  input  logic [dipt_pkg::TIME_W-1:0]     now_ms,
  input  logic [dipt_pkg::TIME_W-1:0]     last_activity_ms,
  input  logic [dipt_pkg::LEVEL_W-1:0]    level_now,
  output dipt_pkg::dipt_res_t             res
);
  import dipt_pkg::*;

  localparam int unsigned DIFF_W = TIME_W + 2;

  function automatic logic [DELAY_W-1:0] sat_delay(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] lim;
    lim = signed'({{(DIFF_W-DELAY_W){1'b0}}, MAX_DELAY});
    return (d > lim) ? MAX_DELAY : d[DELAY_W-1:0];
  endfunction

  function automatic logic [DELAY_W-1:0] min_nz(input logic [DELAY_W-1:0] a,
                                                input logic [DELAY_W-1:0] pending);
    return (pending != '0 && pending < a) ? pending : a;
  endfunction

  logic [TIME_W-1:0]        diff_u;
  logic signed [DIFF_W-1:0] idle;

  logic signed [DIFF_W-1:0] d_stby, d_susp, d_off, d_saver;
  logic ge_stby, ge_susp, ge_off, ge_saver;
  logic ok_stby, ok_susp, ok_off;

  logic [LEVEL_W-1:0] lvl_a, lvl_b, lvl_c;
  logic [DELAY_W-1:0] step;
  logic [DELAY_W-1:0] next;
  logic               saver;

  assign diff_u = now_ms - last_activity_ms;
  assign idle   = signed'({{2{diff_u[TIME_W-1]}}, diff_u});

  assign d_stby  = signed'({{(DIFF_W-DELAY_W){1'b0}}, cfg.standby_after_ms}) - idle;
  assign d_susp  = signed'({{(DIFF_W-DELAY_W){1'b0}}, cfg.suspend_after_ms}) - idle;
  assign d_off   = signed'({{(DIFF_W-DELAY_W){1'b0}}, cfg.off_after_ms}) - idle;
  assign d_saver = signed'({{(DIFF_W-DELAY_W){1'b0}}, cfg.saver_after_ms}) - idle;

  assign ge_stby  = d_stby <= 0;
  assign ge_susp  = d_susp <= 0;
  assign ge_off   = d_off <= 0;
  assign ge_saver = d_saver <= 0;

  assign ok_stby = cfg.standby_after_ms != '0 && !ge_stby;
  assign ok_susp = cfg.suspend_after_ms != '0 && !ge_susp;
  assign ok_off  = cfg.off_after_ms != '0 && !ge_off;

  always_comb begin
    lvl_a = level_now;
    if (cfg.power_mgmt_enable && cfg.off_after_ms != '0 && lvl_a < LVL_OFF && ge_off) begin
      lvl_a = LVL_OFF;
    end
    lvl_b = lvl_a;
    if (cfg.power_mgmt_enable && cfg.suspend_after_ms != '0 && lvl_b < LVL_SUSPEND &&
        ge_susp) begin
      lvl_b = LVL_SUSPEND;
    end
    lvl_c = lvl_b;
    if (cfg.power_mgmt_enable && cfg.standby_after_ms != '0 && lvl_c < LVL_STANDBY &&
        ge_stby) begin
      lvl_c = LVL_STANDBY;
    end
  end

  always_comb begin
    step = '0;
    if (cfg.power_mgmt_enable) begin
      unique case (lvl_c)
        LVL_ON: begin
          if (ok_stby)      step = sat_delay(d_stby);
          else if (ok_susp) step = sat_delay(d_susp);
          else if (ok_off)  step = sat_delay(d_off);
        end
        LVL_STANDBY: begin
          if (ok_susp)      step = sat_delay(d_susp);
          else if (ok_off)  step = sat_delay(d_off);
        end
        LVL_SUSPEND: begin
          if (ok_off)       step = sat_delay(d_off);
        end
        default: step = '0;
      endcase
    end
  end

  always_comb begin
    next  = step;
    saver = 1'b0;
    if (lvl_c == LVL_ON && cfg.saver_after_ms != '0) begin
      if (!ge_saver) begin
        next = min_nz(sat_delay(d_saver), step);
      end else begin
        saver = 1'b1;
        if (cfg.saver_repeat_ms != '0) next = min_nz(cfg.saver_repeat_ms, step);
      end
    end
  end

  assign res.level_next     = lvl_c;
  assign res.level_changed  = lvl_c != level_now;
  assign res.saver_activate = saver;
  assign res.next_check_ms  = next;

endmodule

`default_nettype wire
